// File: src/intra_run_length_pixel_decoder_core_defines.svh
// Assertion macros used by the port-level checker of the run-length pixel decoder.
`ifndef INTRA_RUN_LENGTH_PIXEL_DECODER_CORE_DEFINES_SVH
`define INTRA_RUN_LENGTH_PIXEL_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRLPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irlpd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IRLPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irlpd: next-cycle check failed");

`endif

// File: src/irlpd_pkg.sv
// Package of the run-length pixel decoder: field widths, register codes and shared types.
package irlpd_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned DimW     = 12;
  localparam int unsigned RowOutW  = 11;
  localparam int unsigned ColOutW  = 11;
  localparam int unsigned LenW     = 9;
  localparam int unsigned PendW    = 8;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = DimW;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HALF_HORIZONTAL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HALF_VERTICAL   = 2'd3;

  localparam logic [DimW-1:0] FrameWidthRst  = 12'd320;
  localparam logic [DimW-1:0] FrameHeightRst = 12'd200;

  // Code byte layout.
  localparam int unsigned      SinglePixelBit = 7;
  localparam logic [PendW-1:0] RunBias        = 8'd2;
  localparam logic [LenW-1:0]  MaxFillLen     = 9'd258;

  typedef struct packed {
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
    logic            half_horizontal;
    logic            half_vertical;
  } cfg_t;

  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] column;
    logic [LenW-1:0]    length;
    logic [ColorW-1:0]  color;
    logic               two_rows;
  } fill_t;

endpackage

// File: src/irlpd_step.sv
// Per-byte decode step: next row, column and pending run, and the fill request.
module irlpd_step import irlpd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  cfg_t                              cfg_i,
  input  logic [CodeW-1:0]                  code_i,
  input  logic                              start_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      col_i,
  input  logic [$clog2(MAX_HEIGHT+2)-1:0]   row_i,
  input  logic                              await_i,
  input  logic [PendW-1:0]                  pend_i,
  output logic                              emit_o,
  output fill_t                             fill_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_o,
  output logic [$clog2(MAX_HEIGHT+2)-1:0]   row_o,
  output logic                              await_o,
  output logic [PendW-1:0]                  pend_o
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned RowW   = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned SumW   = ((ColW > LenW) ? ColW : LenW) + 1;
  localparam int unsigned WCmpW  = (SumW > DimW + 1) ? SumW : DimW + 1;
  localparam int unsigned HCmpW  = (RowW > DimW + 1) ? RowW : DimW + 1;

  logic [ColW-1:0]  col0;
  logic [RowW-1:0]  row0;
  logic             await0;
  logic [PendW-1:0] pend0;
  logic [WCmpW-1:0] width_ext, width_eff;
  logic [HCmpW-1:0] height_ext, height_eff;
  logic             done, single, wrap;
  logic [LenW-1:0]  base_len, len;
  logic [SumW-1:0]  sum;

  always_comb begin
    // Frame start clears position and pending run before the byte is used.
    col0   = start_i ? '0 : col_i;
    row0   = start_i ? '0 : row_i;
    await0 = start_i ? 1'b0 : await_i;
    pend0  = start_i ? '0 : pend_i;

    width_ext  = WCmpW'(cfg_i.frame_width);
    width_eff  = (width_ext > WCmpW'(MAX_WIDTH)) ? WCmpW'(MAX_WIDTH) : width_ext;
    height_ext = HCmpW'(cfg_i.frame_height);
    height_eff = (height_ext > HCmpW'(MAX_HEIGHT)) ? HCmpW'(MAX_HEIGHT) : height_ext;

    done     = HCmpW'(row0) >= height_eff;
    single   = code_i[SinglePixelBit];
    base_len = await0 ? LenW'(pend0) : LenW'(1);
    len      = cfg_i.half_horizontal ? {base_len[LenW-2:0], 1'b0} : base_len;
    sum      = SumW'(col0) + SumW'(len);
    wrap     = WCmpW'(sum) >= width_eff;

    emit_o = !done && (await0 || single) && (code_i != '0);

    col_o   = col0;
    row_o   = row0;
    await_o = await0;
    pend_o  = pend0;
    if (!done) begin
      if (!await0 && !single) begin
        // Run header: hold the length until the color byte arrives.
        pend_o  = PendW'(code_i[SinglePixelBit-1:0]) + RunBias;
        await_o = 1'b1;
      end else begin
        await_o = 1'b0;
        if (wrap) begin
          col_o = '0;
          row_o = row0 + RowW'(1) + RowW'(cfg_i.half_vertical);
        end else begin
          col_o = ColW'(sum);
        end
      end
    end

    fill_o.row      = RowOutW'(row0);
    fill_o.column   = ColOutW'(col0);
    fill_o.length   = len;
    fill_o.color    = code_i;
    fill_o.two_rows = cfg_i.half_vertical;
  end

endmodule

// File: src/intra_run_length_pixel_decoder_core.sv
// Top level of the run-length pixel decoder for 8-bit palette intra frames.
// The core takes one payload byte per cycle while in_stall_o is low and turns it
// into at most one fill request (row, column, length, color, two-row flag). Outside
// a run, a byte with bit 7 set is a single pixel of that color; any other byte opens
// a run of (low 7 bits + 2) pixels whose color is the next byte. Half horizontal
// mode doubles every length, half vertical mode flags two rows and steps the row by
// two. Color 0 makes no request but still advances the column. Runs are not clipped
// at the line end; a run that reaches the width sends the next one to column zero
// of the next row. Once the row reaches the frame height, bytes are dropped until a
// byte with frame_start. The core takes one byte per cycle while in_stall_o is low;
// a byte waits in the input register, and its request is loaded into the result
// register once the step completes; that request may wait under out_stall_i while
// the next byte is taken. The decode state loop (column, row, pending run) closes
// through the column add and the width and height compares once per completed byte.
// Configuration writes take effect on the next byte and must only be issued
// while the core is idle.
module intra_run_length_pixel_decoder_core import irlpd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // byte request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CodeW-1:0]    code_byte_i,
  input  logic                frame_start_i,
  // fill request channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RowOutW-1:0]  fill_row_o,
  output logic [ColOutW-1:0]  fill_column_o,
  output logic [LenW-1:0]     fill_length_o,
  output logic [ColorW-1:0]   fill_color_o,
  output logic                two_rows_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT + 2);

  cfg_t             cfg_q;
  logic             s1_valid_q;
  logic [CodeW-1:0] s1_code_q;
  logic             s1_start_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             await_q, await_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             out_valid_q;
  fill_t            out_q, fill_d;
  logic             emit, out_free, step_go, in_accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= FrameWidthRst;
      cfg_q.frame_height    <= FrameHeightRst;
      cfg_q.half_horizontal <= 1'b0;
      cfg_q.half_vertical   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data_i;
        CFG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data_i;
        CFG_HALF_HORIZONTAL: cfg_q.half_horizontal <= cfg_data_i[0];
        CFG_HALF_VERTICAL:   cfg_q.half_vertical   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  irlpd_step #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_step (
    .cfg_i   (cfg_q),
    .code_i  (s1_code_q),
    .start_i (s1_start_q),
    .col_i   (col_q),
    .row_i   (row_q),
    .await_i (await_q),
    .pend_i  (pend_q),
    .emit_o  (emit),
    .fill_o  (fill_d),
    .col_o   (col_d),
    .row_o   (row_d),
    .await_o (await_d),
    .pend_o  (pend_d)
  );

  // The result register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  // A byte that makes no request never waits for the result register.
  assign step_go   = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !step_go;
  assign in_accept = in_valid_i && !in_stall_o;

  // Input register: hold the byte until its step completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (step_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_code_q  <= code_byte_i;
      s1_start_q <= frame_start_i;
    end
  end

  // Decode state: advance once per completed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      await_q <= 1'b0;
      pend_q  <= '0;
    end else if (step_go) begin
      col_q   <= col_d;
      row_q   <= row_d;
      await_q <= await_d;
      pend_q  <= pend_d;
    end
  end

  // Result register: load a new request, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && emit) begin
      out_q <= fill_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fill_row_o    = out_q.row;
  assign fill_column_o = out_q.column;
  assign fill_length_o = out_q.length;
  assign fill_color_o  = out_q.color;
  assign two_rows_o    = out_q.two_rows;

endmodule

// File: src/irlpd_checker.sv
// Port-level checker of the run-length pixel decoder and its bind statement.
`include "intra_run_length_pixel_decoder_core_defines.svh"

module irlpd_checker import irlpd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [LenW-1:0]     fill_length_o,
  input logic [ColorW-1:0]   fill_color_o
);

  // A stalled request stays offered.
  `IRLPD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // The byte channel only stalls behind a blocked result register.
  `IRLPD_ASSERT_NOW(a_in_stall_cause, in_valid_i && in_stall_o, out_valid_o && out_stall_i)

  // Color zero never makes a request, and no fill is empty.
  `IRLPD_ASSERT_NOW(a_fill_nonzero, out_valid_o, (fill_color_o != '0) && (fill_length_o != '0))

  // Runs are at most 129 pixels, doubled at most once.
  `IRLPD_ASSERT_NOW(a_len_max, out_valid_o, fill_length_o <= MaxFillLen)

  // Runs are at least two pixels, so a one-pixel fill comes from a single-pixel byte.
  `IRLPD_ASSERT_NOW(a_single_color, out_valid_o && (fill_length_o == LenW'(1)), fill_color_o[SinglePixelBit])

endmodule

bind intra_run_length_pixel_decoder_core irlpd_checker u_irlpd_checker (.*);

// File: test/irlpd_fill_checker.sv
// Checker of the run-length pixel decoder: predicts fill requests and compares them.
`timescale 1ns / 100ps

module irlpd_fill_checker import irlpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CodeW-1:0]    code_byte_i,
  input  logic                frame_start_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [RowOutW-1:0]  fill_row_i,
  input  logic [ColOutW-1:0]  fill_column_i,
  input  logic [LenW-1:0]     fill_length_i,
  input  logic [ColorW-1:0]   fill_color_i,
  input  logic                two_rows_i,
  input  logic                end_check_i,
  output int unsigned         fail_count_o,
  output int unsigned         outstanding_o,
  output int unsigned         ignored_o
);

  logic [DimW-1:0]    width_q;
  logic [DimW-1:0]    height_q;
  logic               half_h_q;
  logic               half_v_q;
  logic [ColOutW-1:0] column_q;
  logic [DimW-1:0]    row_q;
  logic               awaiting_q;
  logic [LenW-1:0]    pending_q;

  fill_t       expected_fills[$];
  int unsigned mismatches = 0;
  int unsigned ignored    = 0;
  bit          end_seen   = 1'b0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: fill mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the decode state by one byte and queue the fill it makes, if any.
  task automatic decode_code(input logic [CodeW-1:0] code, input logic fs);
    logic [DimW:0] width_lim;
    logic [DimW:0] height_lim;
    logic [LenW:0] run_len;
    logic [DimW:0] next_col;
    fill_t         fill;
    width_lim  = {1'b0, width_q};
    height_lim = {1'b0, height_q};
    if (width_lim > MaxWidthDef) width_lim = (DimW+1)'(MaxWidthDef);
    if (height_lim > MaxHeightDef) height_lim = (DimW+1)'(MaxHeightDef);
    if (fs) begin
      column_q   = '0;
      row_q      = '0;
      awaiting_q = 1'b0;
      pending_q  = '0;
    end
    if ({1'b0, row_q} >= height_lim) begin
      ignored++;
      return;
    end
    if (!awaiting_q && !code[SinglePixelBit]) begin
      pending_q  = LenW'(code[SinglePixelBit-1:0]) + LenW'(RunBias);
      awaiting_q = 1'b1;
      return;
    end
    run_len    = awaiting_q ? {1'b0, pending_q} : (LenW+1)'(1);
    awaiting_q = 1'b0;
    if (half_h_q) run_len = run_len << 1;
    if (code != '0) begin
      fill.row      = row_q[RowOutW-1:0];
      fill.column   = column_q;
      fill.length   = run_len[LenW-1:0];
      fill.color    = code;
      fill.two_rows = half_v_q;
      expected_fills.push_back(fill);
    end
    next_col = (DimW+1)'(column_q) + (DimW+1)'(run_len);
    if (next_col >= width_lim) begin
      column_q = '0;
      row_q    = row_q + DimW'(1) + DimW'(half_v_q);
    end else begin
      column_q = next_col[ColOutW-1:0];
    end
  endtask

  task automatic check_fill();
    fill_t want;
    if (expected_fills.size() == 0) begin
      report_mismatch("unexpected request, row", fill_row_i, 0);
      return;
    end
    want = expected_fills.pop_front();
    if (fill_row_i !== want.row) report_mismatch("fill_row", fill_row_i, want.row);
    if (fill_column_i !== want.column)
      report_mismatch("fill_column", fill_column_i, want.column);
    if (fill_length_i !== want.length)
      report_mismatch("fill_length", fill_length_i, want.length);
    if (fill_color_i !== want.color)
      report_mismatch("fill_color", fill_color_i, want.color);
    if (two_rows_i !== want.two_rows)
      report_mismatch("two_rows", two_rows_i, want.two_rows);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    = FrameWidthRst;
      height_q   = FrameHeightRst;
      half_h_q   = 1'b0;
      half_v_q   = 1'b0;
      column_q   = '0;
      row_q      = '0;
      awaiting_q = 1'b0;
      pending_q  = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:     width_q  = cfg_data_i;
          CFG_FRAME_HEIGHT:    height_q = cfg_data_i;
          CFG_HALF_HORIZONTAL: half_h_q = cfg_data_i[0];
          CFG_HALF_VERTICAL:   half_v_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_fill();
      if (in_valid_i && !in_stall_i) decode_code(code_byte_i, frame_start_i);
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_fills.size() != 0)
          report_mismatch("requests still expected", 0, expected_fills.size());
      end
    end
    fail_count_o  <= mismatches;
    outstanding_o <= expected_fills.size();
    ignored_o     <= ignored;
  end

endmodule

// File: test/tb.sv
// Top of the run-length pixel decoder testbench: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb;
  import irlpd_pkg::*;

  // Hard stop well beyond the slowest correct run.
  localparam int unsigned CycleLimit  = 400000;
  // A byte's request passes the input and result registers; allow some margin.
  localparam int unsigned DrainCycles = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CodeW-1:0]    code_byte = '0;
  logic                frame_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RowOutW-1:0]  fill_row;
  logic [ColOutW-1:0]  fill_column;
  logic [LenW-1:0]     fill_length;
  logic [ColorW-1:0]   fill_color;
  logic                two_rows;
  logic                end_check = 1'b0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned ignored_count;
  int unsigned bytes_sent  = 0;
  int unsigned cycles      = 0;
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 48;

  intra_run_length_pixel_decoder_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .code_byte_i   (code_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .fill_row_o    (fill_row),
    .fill_column_o (fill_column),
    .fill_length_o (fill_length),
    .fill_color_o  (fill_color),
    .two_rows_o    (two_rows)
  );

  irlpd_fill_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .code_byte_i   (code_byte),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .fill_row_i    (fill_row),
    .fill_column_i (fill_column),
    .fill_length_i (fill_length),
    .fill_color_i  (fill_color),
    .two_rows_i    (two_rows),
    .end_check_i   (end_check),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .ignored_o     (ignored_count)
  );

  always #4 clk = ~clk;

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the fill request channel at random, one draw per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Offer one byte request, idling first at random; hold it until accepted.
  task automatic send_code(input logic [CodeW-1:0] code, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    code_byte   <= code;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected request has come back.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles; the core is idle here.
  task automatic apply_geometry(input logic [DimW-1:0] width, input logic [DimW-1:0] height,
                                input logic half_h, input logic half_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_index <= CFG_HALF_HORIZONTAL;
    cfg_data  <= {{(CfgDataW-1){1'b0}}, half_h};
    @(posedge clk);
    cfg_index <= CFG_HALF_VERTICAL;
    cfg_data  <= {{(CfgDataW-1){1'b0}}, half_v};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed frames (singles, run plus color) with some noise bytes and stray
  // frame starts; stop once enough bytes were actually decoded or twice that many were sent.
  task automatic run_frames(input int unsigned target);
    int unsigned      first_sent;
    int unsigned      first_ignored;
    int unsigned      frame_left;
    int unsigned      pick;
    bit               want_color;
    logic [CodeW-1:0] code;
    logic             fs;
    first_sent    = bytes_sent;
    first_ignored = ignored_count;
    frame_left    = 0;
    want_color    = 1'b0;
    while ((bytes_sent - first_sent) - (ignored_count - first_ignored) < target &&
           bytes_sent - first_sent < 2 * target) begin
      fs = 1'b0;
      if (frame_left == 0) begin
        fs         = 1'b1;
        frame_left = $urandom_range(120, 6);
        want_color = 1'b0;
      end
      frame_left--;
      pick = $urandom_range(99);
      if (pick < 10) begin
        code = CodeW'($urandom);
        fs   = fs | ($urandom_range(7) == 0);
      end else if (want_color) begin
        code       = ($urandom_range(7) == 0) ? '0 : CodeW'($urandom);
        want_color = 1'b0;
      end else if (pick < 50) begin
        code = {1'b1, 7'($urandom)};
      end else begin
        code       = {1'b0, 7'($urandom)};
        want_color = 1'b1;
      end
      send_code(code, fs);
    end
  endtask

  task automatic run_phase(input logic [DimW-1:0] width, input logic [DimW-1:0] height,
                           input logic half_h, input logic half_v, input int unsigned mode);
    wait_quiet();
    apply_geometry(width, height, half_h, half_v);
    case (mode)
      0: begin tx_idle_pct = 14; rx_idle_pct = 48; end
      1: begin tx_idle_pct = 48; rx_idle_pct = 14; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
    run_frames(60);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry 320x200: singles at both ends of the color range,
    // shortest and longest runs, and a zero color that makes no request.
    send_code(8'h80, 1'b1);
    send_code(8'hff, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h01, 1'b0);
    send_code(8'h7f, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h7f, 1'b0);
    send_code(8'hff, 1'b0);
    send_code(8'haa, 1'b0);
    send_code(8'h05, 1'b0);
    // Frame start on a color byte: the pending run is dropped, the byte opens a new run.
    send_code(8'h33, 1'b1);
    send_code(8'h80, 1'b0);
    // Frame start while a color is awaited.
    send_code(8'h00, 1'b0);
    send_code(8'h81, 1'b1);

    // One-line frame: finish it, then bytes are ignored until the next frame start.
    wait_quiet();
    apply_geometry(12'd8, 12'd1, 1'b0, 1'b0);
    send_code(8'hff, 1'b1);
    send_code(8'h06, 1'b0);
    send_code(8'h12, 1'b0);
    send_code(8'h90, 1'b0);
    send_code(8'h91, 1'b1);

    // Zero height: every byte is ignored.
    wait_quiet();
    apply_geometry(12'd8, 12'd0, 1'b1, 1'b1);
    send_code(8'h85, 1'b1);
    send_code(8'h02, 1'b0);
    send_code(8'h44, 1'b0);

    // Random frames over several geometries, including zero width, oversized
    // registers, both half modes and an odd height with two-row fills.
    run_phase(12'd16,   12'd6,    1'b0, 1'b0, 0);
    run_phase(12'd0,    12'd3,    1'b0, 1'b0, 0);
    run_phase(12'd37,   12'd5,    1'b1, 1'b0, 0);
    run_phase(12'd24,   12'd7,    1'b0, 1'b1, 1);
    run_phase(12'd4095, 12'd4095, 1'b1, 1'b1, 1);
    run_phase(12'd2048, 12'd1,    1'b1, 1'b0, 1);
    run_phase(12'd1,    12'd2048, 1'b0, 1'b0, 2);
    run_phase(12'd9,    12'd0,    1'b0, 1'b0, 2);
    run_phase(12'd320,  12'd200,  1'b0, 1'b1, 2);

    wait_quiet();
    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
